>>> hw/rtl/ilir_pkg.sv
package ilir_pkg;

  localparam int POS_W  = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    FUNC_READ   = 3'd0,
    FUNC_WRITE  = 3'd1,
    FUNC_INSERT = 3'd2,
    FUNC_REMOVE = 3'd3,
    FUNC_DUMP   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_READ,
    CMD_WRITE,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_DUMP_FIRST,
    CMD_DUMP_NEXT
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  // datapath flags the controller steers by
  typedef struct packed {
    logic cnt_multi;  // more than one entry held
    logic dump_last;  // dump index points at the final entry
  } dp_status_t;

endpackage

>>> hw/rtl/ilir_ctrl.sv
module ilir_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          in_func,
  input  ilir_pkg::dp_status_t dp_st,
  output ilir_pkg::cmd_t      cmd,
  output logic                busy
);
  import ilir_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    busy      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_func)
            FUNC_READ:   cmd = CMD_READ;
            FUNC_WRITE:  cmd = CMD_WRITE;
            FUNC_INSERT: cmd = CMD_INSERT;
            FUNC_REMOVE: cmd = CMD_REMOVE;
            FUNC_DUMP: begin
              cmd = CMD_DUMP_FIRST;
              if (dp_st.cnt_multi) state_nxt = S_DUMP;
            end
            default: cmd = CMD_NONE;
          endcase
        end
      end
      S_DUMP: begin
        busy = 1'b1;
        cmd  = CMD_DUMP_NEXT;
        if (dp_st.dump_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/ilir_dpath.sv
module ilir_dpath #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ilir_pkg::cmd_t               cmd,
  input  logic [ilir_pkg::POS_W-1:0]   in_position,
  input  logic signed [ilir_pkg::DATA_W-1:0] in_value,
  output ilir_pkg::dp_status_t         dp_st,
  output logic                         out_strobe,
  output logic signed [ilir_pkg::DATA_W-1:0] out_data,
  output logic [1:0]                   out_status,
  output logic                         out_last
);
  import ilir_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  logic [DATA_W-1:0] ent_r   [DEPTH];
  logic [DATA_W-1:0] ent_nxt [DEPTH];
  logic [DATA_W-1:0] up_src  [DEPTH];
  logic [DATA_W-1:0] dn_src  [DEPTH];

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  logic              strobe_r, strobe_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              last_r, last_nxt;

  logic [XW-1:0] pos_x, cnt_x, cnt_m1_x, ins_x, rd_x;
  logic          pos_ok, full;
  logic [DATA_W-1:0] rd_data;

  assign pos_x    = XW'(in_position);
  assign cnt_x    = XW'(count_r);
  assign cnt_m1_x = cnt_x - 1'b1;
  assign pos_ok   = pos_x < cnt_x;
  assign full     = count_r == CW'(DEPTH);
  assign ins_x    = pos_ok ? pos_x : cnt_x;
  assign rd_x     = (cmd == CMD_DUMP_NEXT) ? XW'(idx_r) :
                    (cmd == CMD_DUMP_FIRST) ? '0 : pos_x;

  assign dp_st.cnt_multi = count_r > CW'(1);
  assign dp_st.dump_last = (idx_r + 1'b1) == count_r;

  // neighbor taps for the shift moves
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      up_src[i] = ent_r[(i == 0) ? 0 : i - 1];
      dn_src[i] = ent_r[(i == DEPTH - 1) ? i : i + 1];
    end
  end

  // read port: AND-OR select over all entries
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_x == XW'(i)) rd_data = rd_data | ent_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) ent_nxt[i] = ent_r[i];
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    data_nxt   = '0;
    status_nxt = ST_OK;
    last_nxt   = 1'b1;
    case (cmd)
      CMD_READ: begin
        strobe_nxt = 1'b1;
        if (pos_ok) data_nxt = rd_data;
        else        status_nxt = ST_EMPTY;
      end
      CMD_WRITE: begin
        strobe_nxt = 1'b1;
        if (pos_ok) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (pos_x == XW'(i)) ent_nxt[i] = in_value;
          end
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      CMD_INSERT: begin
        strobe_nxt = 1'b1;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (ins_x == XW'(i))
              ent_nxt[i] = in_value;
            else if (XW'(i) > ins_x && XW'(i) <= cnt_x)
              ent_nxt[i] = up_src[i];
          end
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_REMOVE: begin
        strobe_nxt = 1'b1;
        if (pos_ok) begin
          data_nxt = rd_data;
          for (int i = 0; i < DEPTH; i++) begin
            if (XW'(i) >= pos_x && XW'(i) < cnt_m1_x) ent_nxt[i] = dn_src[i];
          end
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      CMD_DUMP_FIRST: begin
        strobe_nxt = 1'b1;
        idx_nxt    = CW'(1);
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          data_nxt = rd_data;
          last_nxt = !dp_st.cnt_multi;
        end
      end
      CMD_DUMP_NEXT: begin
        strobe_nxt = 1'b1;
        data_nxt   = rd_data;
        last_nxt   = dp_st.dump_last;
        idx_nxt    = idx_r + 1'b1;
      end
      default: strobe_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r    <= ent_nxt;
    idx_r    <= idx_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;
  assign out_status = status_r;
  assign out_last   = last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_INSERT && !full) |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the list");
  a_dump_next_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_DUMP_NEXT) |-> idx_r < count_r)
    else $error("dump index past end of list");
`endif

endmodule

>>> hw/rtl/indexed_list_insert_remove.sv
// Channel  | Handshake        | Ports
// ---------+------------------+-----------------------------------------
// command  | start & !busy    | in_func, in_position, in_value
// result   | out_strobe       | out_data, out_status, out_last
//
// Read, write, insert and remove never stall: the whole register list
// shifts at once and the result strobes in the next cycle.
// A dump of N > 0 entries strobes N results on consecutive cycles; busy holds
// while the dump index steps through the list.
// Reset (rst_n low, synchronous) empties the list; entry contents stay
// undefined until written. The receiver cannot stall the result channel.
module indexed_list_insert_remove #(
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_func,
  input  logic [ilir_pkg::POS_W-1:0]        in_position,
  input  logic signed [ilir_pkg::DATA_W-1:0] in_value,
  output logic                              out_strobe,
  output logic signed [ilir_pkg::DATA_W-1:0] out_data,
  output logic [1:0]                        out_status,
  output logic                              out_last
);
  import ilir_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_st;

  // sequence the transfers: one command per accepted item, one per dump step
  ilir_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .dp_st   (dp_st),
    .cmd     (cmd),
    .busy    (busy)
  );

  // hold the list, shift it on edits, register each result
  ilir_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_position (in_position),
    .in_value    (in_value),
    .dp_st       (dp_st),
    .out_strobe  (out_strobe),
    .out_data    (out_data),
    .out_status  (out_status),
    .out_last    (out_last)
  );

`ifndef ASSERT_OFF
  // every accepted valid command yields a result transfer next cycle
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func <= FUNC_DUMP) |=> out_strobe)
    else $error("accepted command gave no result");
  // a dump in progress strobes every cycle
  a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe)
    else $error("dump stream broke");
  // a result not marked last is followed by another
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> busy)
    else $error("unmarked result with no dump running");
  // error results carry zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> out_data == '0)
    else $error("error result with nonzero data");
`endif

endmodule
